// ----- rtl/cti_pkg.sv -----
// Shared types and constants for the calibration table interpolator.
// Used by cti_muldiv, calibration_table_interpolator_unit and the bench; no dependencies.
package cti_pkg;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_E2T  = 2'd1,
      OP_T2E  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FLAT  = 2'd2
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         entry_index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      status_type         status;
   } rsp_type;

   typedef enum logic {
      MD_MUL = 1'b0,
      MD_DIV = 1'b1
   } md_mode_type;

   typedef struct packed {
      logic        start;
      md_mode_type mode;
   } md_cmd_type;

   localparam logic [8:0]         LEN_RESET = 9'd256;
   localparam logic signed [10:0] ZO_RESET  = -11'sd50;

endpackage

// ----- rtl/cti_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cti_muldiv.sv -----
// Bit-serial unsigned multiplier / restoring divider built around one adder.
// Depends on cti_pkg for the command struct.
module cti_muldiv #(
   parameter int A_W = 33,
   parameter int N_W = 49
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cti_pkg::md_cmd_type   cmd,
   input  logic [A_W-1:0]        opa,
   input  logic [N_W-1:0]        opb,
   output logic                  done,
   output logic [A_W+N_W-1:0]    result
);

   localparam int CW = $clog2(N_W + 1);

   logic [A_W-1:0]       acc_ff, acc_in;
   logic [N_W-1:0]       sh_ff, sh_in;
   logic [A_W-1:0]       opa_ff, opa_in;
   cti_pkg::md_mode_type mode_ff, mode_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [A_W:0]   trial;
   logic [A_W+1:0] add_x, add_y, add_sum;
   logic           add_sub;

   // One shared adder: subtract for a divide step, add for a multiply step.
   always_comb begin
      trial = {acc_ff, sh_ff[N_W-1]};
      if (mode_ff == cti_pkg::MD_DIV) begin
         add_x   = {1'b0, trial};
         add_y   = {2'b00, opa_ff};
         add_sub = 1'b1;
      end else begin
         add_x   = {2'b00, acc_ff};
         add_y   = sh_ff[0] ? {2'b00, opa_ff} : '0;
         add_sub = 1'b0;
      end
      add_sum = add_x + (add_sub ? ~add_y : add_y) + {{(A_W+1){1'b0}}, add_sub};
   end

   always_comb begin
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opa_in  = opa_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in  = '0;
         sh_in   = opb;
         opa_in  = opa;
         mode_in = cmd.mode;
         cnt_in  = CW'(N_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (mode_ff == cti_pkg::MD_DIV) begin
            // keep the trial remainder on a borrow, else take the difference
            if (add_sum[A_W+1]) begin
               acc_in = trial[A_W-1:0];
               sh_in  = {sh_ff[N_W-2:0], 1'b0};
            end else begin
               acc_in = add_sum[A_W-1:0];
               sh_in  = {sh_ff[N_W-2:0], 1'b1};
            end
         end else begin
            acc_in = add_sum[A_W:1];
            sh_in  = {add_sum[0], sh_ff[N_W-1:1]};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= cti_pkg::MD_MUL;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opa_ff <= opa_in;
   end

   assign done   = done_ff;
   assign result = {acc_ff, sh_ff};

endmodule

// ----- rtl/calibration_table_interpolator_unit.sv -----
// Top level of the calibration table interpolator: sequencer, table, registers.
// Depends on cti_pkg, cti_ram and cti_muldiv.
//
// Usage: drive a request word on req_item and raise start; the word is taken at
// a clock edge where start is high and busy is low. Exactly one response word
// comes back on rsp_item, flagged by rsp_valid for a single cycle; the receiver
// cannot stall it, so sample it whenever rsp_valid is high.
// Load (op 0) and the unused opcode answer in the next cycle and the unit takes
// a new word in that same cycle, one word per cycle.
// Electrical-to-technical scans the table one entry per cycle through the RAM
// read port, fetches the two segment ends, then runs a bit-serial divide of
// 33+FRAC_BITS steps; a flat segment answers without the divide, and a failed
// search answers once the scan has checked the last entry without a hit.
// Technical-to-electrical computes the segment index directly, fetches both
// ends, then runs the same serial unit for 33+FRAC_BITS multiply steps; a value
// out of range answers without the fetch. Busy stays high for the whole item
// and drops in the cycle the response is shown.
// Configuration: APB-style, table_length at 0x0, zero_offset at 0x4; write only
// while idle. Reset restores table_length 256 and zero_offset -50 and returns
// the sequencer to idle; table contents stay undefined until loaded.
module calibration_table_interpolator_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cti_pkg::req_type    req_item,
   output logic                rsp_valid,
   output cti_pkg::rsp_type    rsp_item,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // index, count and degree widths
   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int LW  = $clog2(TABLE_DEPTH + 1);
   localparam int DW  = ((LW > 11) ? LW : 11) + 2;
   localparam int VIW = 32 - FRAC_BITS;
   localparam int TM  = (VIW > 11) ? VIW : 11;
   localparam int TW  = ((TM > LW + 1) ? TM : LW + 1) + 2;
   // serial unit operand widths
   localparam int A_W = 33;
   localparam int QW  = 33 + FRAC_BITS;
   localparam int MW  = ((DW + FRAC_BITS > 32) ? DW + FRAC_BITS : 32) + 1;
   localparam int N_W = (QW > MW) ? QW : MW;
   localparam int PW  = A_W + N_W;
   localparam int WW  = PW + 2;

   localparam logic signed [32:0] TENTH_Q =
      33'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic signed [WW-1:0] SAT_HI = WW'(32'sh7fff_ffff);
   localparam logic signed [WW-1:0] SAT_LO = WW'(32'sh8000_0000);

   localparam logic REG_LENGTH = 1'b0;
   localparam logic REG_OFFSET = 1'b1;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_SCAN   = 11'b000_0000_0010,
      S_RANGE  = 11'b000_0000_0100,
      S_FETCH0 = 11'b000_0000_1000,
      S_FETCH1 = 11'b000_0001_0000,
      S_FETCH2 = 11'b000_0010_0000,
      S_SETUP  = 11'b000_0100_0000,
      S_LAUNCH = 11'b000_1000_0000,
      S_RUN    = 11'b001_0000_0000,
      S_NEG    = 11'b010_0000_0000,
      S_FIN    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [8:0]         len_ff;
   logic signed [10:0] zo_ff;
   logic               cfg_wr;

   // item and sequencer registers
   cti_pkg::op_type    op_ff, op_in;
   logic signed [31:0] v_ff, v_in;
   logic [LW-1:0]      addr_ff, addr_in;
   logic [LW-1:0]      chk_ff, chk_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IW-1:0]      seg_ff, seg_in;
   logic signed [TW-1:0] t_ff, t_in;
   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] hi_ff, hi_in;
   logic signed [DW-1:0] deg_ff, deg_in;
   logic signed [32:0] k_ff, k_in;
   logic signed [MW-1:0] diff_ff, diff_in;
   logic               sign_ff, sign_in;
   logic signed [WW-1:0] wide_ff, wide_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cti_pkg::rsp_type   rsp_ff, rsp_in;

   // combinational helpers
   logic [LW-1:0]      n_eff, n_m1, n_m2;
   logic signed [TW-1:0] n_s;
   logic               accept;
   logic               ram_we;
   logic [IW-1:0]      ram_waddr, ram_raddr;
   logic [31:0]        ram_rdata;
   logic signed [31:0] ent;
   logic signed [32:0] scan_diff;
   logic               scan_hit, scan_last;
   logic [A_W-1:0]     k_mag;
   logic [MW-1:0]      d_mag;
   logic [N_W-1:0]     md_opb;
   cti_pkg::md_cmd_type md_cmd;
   logic               md_done;
   logic [PW-1:0]      md_result;
   logic [WW-1:0]      mag;
   logic signed [WW-1:0] fin_sum;
   logic signed [31:0] sat_val;

   // ---------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= cti_pkg::LEN_RESET;
         zo_ff  <= cti_pkg::ZO_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_LENGTH: len_ff <= pwdata[8:0];
            REG_OFFSET: zo_ff  <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LENGTH: prdata = {23'd0, len_ff};
         REG_OFFSET: prdata = 32'(zo_ff);
         default:    prdata = '0;
      endcase
   end

   // Clamp the table length into 2..TABLE_DEPTH.
   always_comb begin
      priority if (len_ff < 9'd2) begin
         n_eff = LW'(2);
      end else if (32'(len_ff) > 32'(TABLE_DEPTH)) begin
         n_eff = LW'(TABLE_DEPTH);
      end else begin
         n_eff = LW'(len_ff);
      end
      n_m1 = n_eff - LW'(1);
      n_m2 = n_eff - LW'(2);
      n_s  = TW'($signed({1'b0, n_eff}));
   end

   // ---------------------------------------------------------------
   // Calibration table
   // ---------------------------------------------------------------
   assign accept    = start && !busy;
   assign ram_we    = accept && (req_item.op == cti_pkg::OP_LOAD) &&
                      (32'(req_item.entry_index) < 32'(TABLE_DEPTH));
   assign ram_waddr = IW'(req_item.entry_index);

   always_comb begin
      unique case (state_ff)
         S_SCAN:   ram_raddr = addr_ff[IW-1:0];
         S_FETCH1: ram_raddr = IW'(seg_ff + IW'(1));
         default:  ram_raddr = seg_ff;
      endcase
   end

   cti_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_item.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ent = ram_rdata;

   // Scan test runs one entry behind the address counter.
   assign scan_diff = 33'(v_ff) - 33'(ent);
   assign scan_hit  = chk_vld_ff && (scan_diff < TENTH_Q);
   assign scan_last = chk_vld_ff && (chk_ff == n_m1);

   // ---------------------------------------------------------------
   // Serial multiply / divide unit
   // ---------------------------------------------------------------
   assign k_mag  = k_ff[32] ? A_W'(-k_ff) : A_W'(k_ff);
   assign d_mag  = diff_ff[MW-1] ? MW'(-diff_ff) : MW'(diff_ff);
   assign md_opb = (op_ff == cti_pkg::OP_E2T) ? (N_W'(d_mag) << FRAC_BITS) : N_W'(d_mag);

   always_comb begin
      md_cmd.start = (state_ff == S_LAUNCH) &&
                     !((op_ff == cti_pkg::OP_E2T) && (k_ff == 33'sd0));
      md_cmd.mode  = (op_ff == cti_pkg::OP_E2T) ? cti_pkg::MD_DIV : cti_pkg::MD_MUL;
   end

   cti_muldiv #(
      .A_W (A_W),
      .N_W (N_W)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md_cmd),
      .opa    (k_mag),
      .opb    (md_opb),
      .done   (md_done),
      .result (md_result)
   );

   // Quotient sits in the low half after a divide; the product fills it all.
   assign mag = (op_ff == cti_pkg::OP_E2T) ? WW'(md_result[N_W-1:0]) : WW'(md_result);

   // Final add: segment degree plus quotient, or entry plus floored product.
   always_comb begin
      if (op_ff == cti_pkg::OP_E2T) begin
         fin_sum = wide_ff + (WW'(deg_ff) <<< FRAC_BITS);
      end else begin
         fin_sum = (wide_ff >>> FRAC_BITS) + WW'(hi_ff);
      end
      priority if (fin_sum > SAT_HI) begin
         sat_val = 32'sh7fff_ffff;
      end else if (fin_sum < SAT_LO) begin
         sat_val = 32'sh8000_0000;
      end else begin
         sat_val = fin_sum[31:0];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      v_in         = v_ff;
      addr_in      = addr_ff;
      chk_in       = chk_ff;
      chk_vld_in   = chk_vld_ff;
      seg_in       = seg_ff;
      t_in         = t_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      deg_in       = deg_ff;
      k_in         = k_ff;
      diff_in      = diff_ff;
      sign_in      = sign_ff;
      wide_in      = wide_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_item.op;
               v_in       = req_item.value;
               addr_in    = '0;
               chk_vld_in = 1'b0;
               t_in       = TW'(req_item.value >>> FRAC_BITS) - TW'(zo_ff) + TW'(1);
               unique case (req_item.op)
                  cti_pkg::OP_E2T: state_in = S_SCAN;
                  cti_pkg::OP_T2E: state_in = S_RANGE;
                  cti_pkg::OP_LOAD,
                  cti_pkg::OP_NONE: begin
                     // answer at once: zero result, status ok
                     rsp_valid_in  = 1'b1;
                     rsp_in.result = '0;
                     rsp_in.status = cti_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            priority if (scan_hit) begin
               // clamp so the segment's upper end stays inside the table
               seg_in   = (chk_ff > n_m2) ? IW'(n_m2) : IW'(chk_ff);
               state_in = S_FETCH0;
            end else if (scan_last) begin
               rsp_valid_in  = 1'b1;
               rsp_in.result = '0;
               rsp_in.status = cti_pkg::ST_RANGE;
               state_in      = S_IDLE;
            end else begin
               chk_in     = addr_ff;
               chk_vld_in = 1'b1;
               addr_in    = addr_ff + LW'(1);
            end
         end
         S_RANGE: begin
            if (t_ff >= n_s) begin
               rsp_valid_in  = 1'b1;
               rsp_in.result = '0;
               rsp_in.status = cti_pkg::ST_RANGE;
               state_in      = S_IDLE;
            end else begin
               // segment below the first entry past the value, never below zero
               seg_in   = (t_ff <= TW'(1)) ? '0 : IW'(t_ff - TW'(1));
               state_in = S_FETCH0;
            end
         end
         S_FETCH0: begin
            state_in = S_FETCH1;
         end
         S_FETCH1: begin
            lo_in    = ent;
            state_in = S_FETCH2;
         end
         S_FETCH2: begin
            hi_in    = ent;
            deg_in   = DW'($signed({1'b0, seg_ff})) + DW'(zo_ff) +
                       ((op_ff == cti_pkg::OP_T2E) ? DW'(1) : DW'(0));
            state_in = S_SETUP;
         end
         S_SETUP: begin
            k_in = 33'(hi_ff) - 33'(lo_ff);
            if (op_ff == cti_pkg::OP_E2T) begin
               diff_in = MW'(v_ff) - MW'(lo_ff);
            end else begin
               diff_in = MW'(v_ff) - (MW'(deg_ff) <<< FRAC_BITS);
            end
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            if ((op_ff == cti_pkg::OP_E2T) && (k_ff == 33'sd0)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.result = '0;
               rsp_in.status = cti_pkg::ST_FLAT;
               state_in      = S_IDLE;
            end else begin
               sign_in  = k_ff[32] ^ diff_ff[MW-1];
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (md_done) begin
               state_in = S_NEG;
            end
         end
         S_NEG: begin
            wide_in  = sign_ff ? -$signed(mag) : $signed(mag);
            state_in = S_FIN;
         end
         S_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_in.result = sat_val;
            rsp_in.status = cti_pkg::ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      v_ff    <= v_in;
      addr_ff <= addr_in;
      chk_ff  <= chk_in;
      seg_ff  <= seg_in;
      t_ff    <= t_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      deg_ff  <= deg_in;
      k_ff    <= k_in;
      diff_ff <= diff_in;
      sign_ff <= sign_in;
      wide_ff <= wide_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- bench/conversion_checker.sv -----
// Response checker for calibration_table_interpolator_unit: mirrors the calibration
// table and both registers, predicts each response word and compares it.
// Depends on cti_pkg.
module conversion_checker #(
   parameter logic [2:0] LEN_ADDR = 3'h0,
   parameter logic [2:0] ZO_ADDR  = 3'h4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  cti_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  cti_pkg::rsp_type rsp_item,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               mismatch_count,
   output int               words_awaited
);
   import cti_pkg::*;

   localparam int     DEPTH   = 256;
   localparam int     FRAC    = 16;
   localparam longint ONE_Q   = longint'(1) << FRAC;
   localparam longint TENTH_Q = (ONE_Q + 5) / 10;
   localparam longint MAX_Q   = (longint'(1) << 31) - 1;
   localparam longint MIN_Q   = -(longint'(1) << 31);

   logic signed [31:0] cal_entry [DEPTH];
   logic [8:0]         length_reg;
   logic signed [10:0] offset_reg;
   rsp_type            awaited_q [$];
   int                 errors = 0;

   task automatic report_mismatch(input string what);
      $display("%0t: response word wrong: %s", $time, what);
      errors++;
   endtask

   // Work out the response word of one request and apply its effect on the table.
   function automatic rsp_type convert_word(input req_type w);
      longint  v, zo, lo, hi, k, d, q, res;
      int      n, i, hit, s;
      rsp_type r;
      v   = longint'($signed(w.value));
      zo  = longint'(offset_reg);
      n   = (length_reg < 2) ? 2 : (length_reg > DEPTH) ? DEPTH : int'(length_reg);
      hit = -1;
      res = 0;
      r.status = ST_OK;
      case (w.op)
         OP_LOAD: cal_entry[w.entry_index] = w.value;
         OP_E2T: begin
            // first entry that lies above the value minus a tenth
            for (i = 0; i < n; i++)
               if (hit < 0 && v - longint'(cal_entry[i]) < TENTH_Q) hit = i;
            if (hit < 0) begin
               r.status = ST_RANGE;
            end else begin
               s  = (hit > n - 2) ? n - 2 : hit;
               lo = cal_entry[s];
               k  = longint'(cal_entry[s + 1]) - lo;
               if (k == 0) r.status = ST_FLAT;
               else res = (s + zo) * ONE_Q + ((v - lo) * ONE_Q) / k;
            end
         end
         OP_T2E: begin
            // first entry whose degree exceeds the value
            for (i = 0; i < n; i++)
               if (hit < 0 && (i + zo) * ONE_Q > v) hit = i;
            if (hit < 0) begin
               r.status = ST_RANGE;
            end else begin
               s  = (hit < 1) ? 1 : hit;
               hi = cal_entry[s];
               k  = hi - longint'(cal_entry[s - 1]);
               d  = v - (s + zo) * ONE_Q;
               q  = d >>> FRAC;
               res = hi + k * q + ((k * (d - q * ONE_Q)) >>> FRAC);
            end
         end
         default: ;
      endcase
      if (r.status != ST_OK) res = 0;
      if (res > MAX_Q) res = MAX_Q;
      else if (res < MIN_Q) res = MIN_Q;
      r.result = res[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_q.delete();
         length_reg = LEN_RESET;
         offset_reg = ZO_RESET;
      end else begin
         if (rsp_valid) begin
            if (awaited_q.size() == 0) begin
               report_mismatch("response word with none awaited");
            end else begin
               want = awaited_q.pop_front();
               if (rsp_item.result !== want.result)
                  report_mismatch($sformatf("result %h, predicted %h",
                                            rsp_item.result, want.result));
               if (rsp_item.status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_item.status, want.status));
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == LEN_ADDR) length_reg = pwdata[8:0];
            else if (paddr == ZO_ADDR) offset_reg = pwdata[10:0];
         end
         if (start && !busy) awaited_q.push_back(convert_word(req_item));
      end
      mismatch_count <= errors;
      words_awaited  <= awaited_q.size();
   end

endmodule

// ----- bench/calibration_table_interpolator_unit_test.sv -----
// Stimulus and verdict for calibration_table_interpolator_unit: loads tables,
// sweeps register settings and conversions; conversion_checker does the checking.
// Depends on cti_pkg, conversion_checker and the unit under test.
module calibration_table_interpolator_unit_test;
   import cti_pkg::*;

   localparam logic [2:0] LEN_ADDR       = 3'h0;
   localparam logic [2:0] ZO_ADDR        = 3'h4;
   localparam int         ONE            = 65536;
   localparam int         TENTH          = 6554;
   localparam int         DEG_LO         = -1024 * ONE;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         SETTLE_CYCLES  = 400;
   localparam int         PHASES         = 10;
   localparam int         WORDS_PER_PHASE = 140;

   // shapes of a freshly loaded table
   typedef enum int {
      RISING    = 0,
      FALLING   = 1,
      STEPPED   = 2,
      SCATTERED = 3
   } profile_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int mismatch_count;
   int words_awaited;
   int idle_pct;
   int length_now;
   int offset_now;
   int quiet_cycles;
   int shadow [256];

   calibration_table_interpolator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   conversion_checker #(
      .LEN_ADDR (LEN_ADDR),
      .ZO_ADDR  (ZO_ADDR)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .words_awaited  (words_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run once nothing has moved on any port for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("calibration_table_interpolator_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word and hold it until the unit takes it. Returns at the
   // accepting edge with start still high; the caller drives the next step.
   task automatic send_word(input op_type op, input logic [7:0] idx,
                            input logic [31:0] val);
      while ($urandom_range(0, 99) < idle_pct) begin
         // idle cycle: drop start and scramble the ignored payload
         start    <= 1'b0;
         req_item <= '{op: op_type'($urandom_range(0, 3)), entry_index: 8'($urandom),
                       value: $urandom};
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{op: op, entry_index: idx, value: val};
      do @(posedge clock); while (busy);
   endtask

   // Drop start and advance until every awaited word is back and the unit idles.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (words_awaited != 0 || busy);
   endtask

   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write both registers and track the length the unit will actually use.
   task automatic configure(input logic [8:0] len_code, input int zo);
      write_register(LEN_ADDR, {23'd0, len_code});
      write_register(ZO_ADDR, zo);
      length_now = (len_code < 2) ? 2 : (len_code > 256) ? 256 : int'(len_code);
      offset_now = zo;
   endtask

   // Load entries 0 .. length_now-1 so that no conversion reads an unwritten entry.
   task automatic fill_table(input profile_type shape);
      int j, val, step;
      val = int'($urandom_range(0, 2 ** 25)) - 2 ** 24;
      for (j = 0; j < length_now; j++) begin
         step = int'($urandom_range(1, 2 ** 18));
         case (shape)
            RISING:  val += step;
            FALLING: val -= step;
            STEPPED: if ($urandom_range(0, 3) != 0) val += step;
            default: val = $urandom;
         endcase
         shadow[j] = val;
         send_word(OP_LOAD, j[7:0], val);
      end
   endtask

   // One random word: mostly conversions aimed at the loaded table, some loads,
   // a few unused opcodes and fully random values.
   task automatic random_word();
      int pick, sub, j, v;
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);
      j    = $urandom_range(0, length_now - 1);
      if (pick < 10) begin
         j = $urandom_range(0, 255);
         if (j < length_now && sub != 0) begin
            v = shadow[j] + int'($urandom_range(0, 2 * ONE)) - ONE;
            shadow[j] = v;
         end else begin
            v = $urandom;
         end
         send_word(OP_LOAD, j[7:0], v);
      end else if (pick < 13) begin
         send_word(OP_NONE, 8'($urandom), $urandom);
      end else if (pick < 56) begin
         case (sub)
            0:       v = $urandom;
            1:       v = shadow[j];
            2:       v = shadow[j] + TENTH - int'($urandom_range(0, 1));
            default: v = shadow[j] + int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
         endcase
         send_word(OP_E2T, 8'($urandom), v);
      end else begin
         case (sub)
            0:       v = $urandom;
            1:       v = (j + offset_now) * ONE;
            default: v = (j + offset_now) * ONE + int'($urandom_range(0, 2 * ONE)) - ONE / 2;
         endcase
         send_word(OP_T2E, 8'($urandom), v);
      end
   endtask

   initial begin
      int p;
      logic [8:0] len_code;
      int zo;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      idle_pct     = 18;
      length_now   = 256;
      offset_now   = -50;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words on a two-entry table at the lowest offset; a length code
      // of zero must act as two.
      configure(9'd0, -1024);
      send_word(OP_LOAD, 8'd0, 32'd0);
      send_word(OP_LOAD, 8'd1, ONE);
      send_word(OP_E2T, 8'd0, 32'd0);
      send_word(OP_E2T, 8'd0, ONE / 2);
      // either side of the tenth margin on the last entry
      send_word(OP_E2T, 8'd0, ONE + TENTH - 1);
      send_word(OP_E2T, 8'd0, ONE + TENTH);
      send_word(OP_E2T, 8'd0, 32'h7fff_ffff);
      send_word(OP_E2T, 8'd0, 32'h8000_0000);
      send_word(OP_T2E, 8'd0, 32'h8000_0000);
      send_word(OP_T2E, 8'd0, 32'h7fff_ffff);
      send_word(OP_T2E, 8'd0, DEG_LO + ONE / 4);
      // below the first degree: extrapolate on the first segment
      send_word(OP_T2E, 8'd0, DEG_LO - ONE / 4);
      send_word(OP_NONE, 8'hff, 32'h5a5a_5a5a);
      // flat segment
      send_word(OP_LOAD, 8'd1, 32'd0);
      send_word(OP_E2T, 8'd0, 32'd0);
      send_word(OP_T2E, 8'd0, DEG_LO + 100);
      // falling segment, quotient overflows high
      send_word(OP_LOAD, 8'd1, 32'hffff_ffff);
      send_word(OP_E2T, 8'd0, 32'h8000_0000);
      send_word(OP_LOAD, 8'hff, 32'hffff_ffff);
      // widest possible segment
      send_word(OP_LOAD, 8'd0, 32'h7fff_ffff);
      send_word(OP_LOAD, 8'd1, 32'h8000_0000);
      send_word(OP_E2T, 8'd0, 32'h7fff_ffff);
      send_word(OP_T2E, 8'd0, 32'd0);

      // Random phases: register extremes and the reset values first, then random
      // settings; the sender idles 18 percent, then 53 percent, then never.
      for (p = 0; p < PHASES; p++) begin
         idle_pct = (p < 4) ? 18 : (p < 7) ? 53 : 0;
         case (p)
            0:       begin len_code = 9'd511; zo = 1023;  end
            1:       begin len_code = 9'd1;   zo = -1024; end
            2:       begin len_code = 9'd256; zo = -50;   end
            default: begin
               len_code = 9'($urandom_range(2, 40));
               zo       = int'($urandom_range(0, 2047)) - 1024;
            end
         endcase
         configure(len_code, zo);
         fill_table(profile_type'($urandom_range(0, 3)));
         repeat (WORDS_PER_PHASE) random_word();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("calibration_table_interpolator_unit: match");
      else
         $display("calibration_table_interpolator_unit: mismatch");
      $finish;
   end

endmodule

// ----- calibration_table_interpolator_unit.f -----
rtl/cti_pkg.sv
rtl/cti_ram.sv
rtl/cti_muldiv.sv
rtl/calibration_table_interpolator_unit.sv
bench/conversion_checker.sv
bench/calibration_table_interpolator_unit_test.sv
